// File: design/nts_pkg.sv
// Package with request codes, status codes and sequencer states for the timestamp search.
package nts_pkg;

  localparam int unsigned TIME_W   = 32;
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FOUND_W  = 10;

  typedef logic [REQ_W-1:0]    req_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [TIME_W-1:0]   time_t;

  localparam req_t REQ_APPEND = 2'd0;
  localparam req_t REQ_QUERY  = 2'd1;
  localparam req_t REQ_CLEAR  = 2'd2;
  localparam req_t REQ_UNUSED = 2'd3;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_FULL  = 2'd1;
  localparam status_t STATUS_EMPTY = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_PREV,
    ST_NEXT
  } state_t;

  // Absolute difference of two timestamps; the one compare-and-subtract unit
  // that every probe and neighbor check goes through.
  function automatic time_t abs_gap(input time_t a, input time_t b);
    abs_gap = (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// File: design/nearest_timestamp_search.sv
// Top level of the nearest-timestamp search table: storage, search sequencer and result register.
//
//  Channel  | Ports                                          | Transfer rule
//  ---------+------------------------------------------------+------------------------------------
//  request  | start, busy, in_req_type, in_time_value        | start high while busy is low
//  result   | out_valid, out_status, out_found_index,        | out_valid high for one cycle; the
//           | out_exact_match                                | receiver takes it on that cycle
//
//  Append, clear and unused requests, and queries on an empty table, need no search; the
//  result appears in the cycle after the request transfer and busy stays low.
//  A query otherwise runs a binary search of at most ceil(log2(entries+1)) probes, plus up
//  to two neighbor reads. The single read port of the timestamp memory paces the search:
//  each probe or neighbor read uses it once.
//  Reset clears the entry count and the sequencer; the memory contents are not cleared.
//  The receiver cannot stall, so a finished result never waits.
module nearest_timestamp_search #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  nts_pkg::req_t            in_req_type,
  input  nts_pkg::time_t           in_time_value,
  output logic                     out_valid,
  output nts_pkg::status_t         out_status,
  output logic [nts_pkg::FOUND_W-1:0] out_found_index,
  output logic                     out_exact_match
);
  import nts_pkg::*;

  // Address width, count width (holds the depth itself) and a width wide enough
  // for both the address and the reported index.
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned IW = (AW > FOUND_W) ? AW : FOUND_W;

  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
  localparam logic [CW-1:0] ONE_C   = CW'(1);

  // Timestamp storage: one write port for appends, one registered read port
  // that the search sequencer uses once per cycle.
  time_t time_mem [TABLE_DEPTH];

  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   lo_r, lo_nxt;       // lowest index still in range
  logic [CW-1:0]   hi_r, hi_nxt;       // one past the highest index still in range
  logic [AW-1:0]   mid_r, mid_nxt;     // index whose data arrives in rd_data_r
  logic [AW-1:0]   best_r, best_nxt;
  time_t           best_gap_r, best_gap_nxt;
  logic            have_r, have_nxt;
  time_t           key_r, key_nxt;
  time_t           rd_data_r;

  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;
  logic [AW-1:0]   out_index_r, out_index_nxt;
  logic            out_exact_r, out_exact_nxt;

  logic [AW-1:0]   rd_addr;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            accept;
  logic [IW-1:0]   index_ext;

  assign accept = start && (state_r == ST_IDLE);

  // Memory ports: write on an append, read every cycle at the sequencer's address.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      time_mem[wr_addr] <= in_time_value;
    end
    rd_data_r <= time_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      have_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      have_r      <= have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers need no reset.
  always_ff @(posedge clk) begin
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    mid_r        <= mid_nxt;
    best_r       <= best_nxt;
    best_gap_r   <= best_gap_nxt;
    key_r        <= key_nxt;
    out_status_r <= out_status_nxt;
    out_index_r  <= out_index_nxt;
    out_exact_r  <= out_exact_nxt;
  end

  // Sequencer. In ST_PROBE the data of the probe at mid_r is in rd_data_r; the
  // same cycle updates the range and issues the read for the next probe. Unless a
  // probe hits the key exactly, ST_PREV then looks at the entry just before the best
  // probe and ST_NEXT at the entry just after the best entry found so far.
  always_comb begin
    time_t         gap;
    logic          better;
    logic [CW-1:0] lo_n;
    logic [CW-1:0] hi_n;
    logic [CW-1:0] span;
    logic [CW-1:0] mid_w;
    logic [AW-1:0] best_n;
    time_t         gap_n;
    logic          finish;

    state_nxt      = state_r;
    count_nxt      = count_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    mid_nxt        = mid_r;
    best_nxt       = best_r;
    best_gap_nxt   = best_gap_r;
    have_nxt       = have_r;
    key_nxt        = key_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_index_nxt  = out_index_r;
    out_exact_nxt  = out_exact_r;
    rd_addr        = mid_r;
    wr_en          = 1'b0;
    wr_addr        = count_r[AW-1:0];

    gap    = abs_gap(rd_data_r, key_r);
    better = !have_r || (gap < best_gap_r);
    lo_n   = lo_r;
    hi_n   = hi_r;
    span   = '0;
    mid_w  = '0;
    best_n = best_r;
    gap_n  = best_gap_r;
    finish = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = STATUS_OK;
          out_index_nxt  = '0;
          out_exact_nxt  = 1'b0;
          key_nxt        = in_time_value;
          case (in_req_type)
            REQ_APPEND: begin
              if (count_r == DEPTH_C) begin
                out_status_nxt = STATUS_FULL;
              end else begin
                wr_en     = 1'b1;
                count_nxt = count_r + ONE_C;
              end
            end
            REQ_QUERY: begin
              if (count_r == '0) begin
                out_status_nxt = STATUS_EMPTY;
              end else begin
                // Search over the whole table; the result waits for the sequencer.
                out_valid_nxt = 1'b0;
                lo_nxt        = '0;
                hi_nxt        = count_r;
                mid_w         = (count_r - ONE_C) >> 1;
                mid_nxt       = mid_w[AW-1:0];
                rd_addr       = mid_w[AW-1:0];
                have_nxt      = 1'b0;
                state_nxt     = ST_PROBE;
              end
            end
            REQ_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ST_PROBE: begin
        if (better) begin
          best_n = mid_r;
          gap_n  = gap;
        end
        have_nxt = 1'b1;
        if (rd_data_r == key_r) begin
          finish = 1'b1;
        end else begin
          if (rd_data_r < key_r) begin
            lo_n = CW'(mid_r) + ONE_C;
          end else begin
            hi_n = CW'(mid_r);
          end
          lo_nxt = lo_n;
          hi_nxt = hi_n;
          if (lo_n < hi_n) begin
            span    = hi_n - lo_n - ONE_C;
            mid_w   = lo_n + (span >> 1);
            mid_nxt = mid_w[AW-1:0];
            rd_addr = mid_w[AW-1:0];
          end else if (best_n != '0) begin
            mid_nxt   = best_n - AW'(1);
            rd_addr   = best_n - AW'(1);
            state_nxt = ST_PREV;
          end else if ((CW'(best_n) + ONE_C) < count_r) begin
            mid_nxt   = best_n + AW'(1);
            rd_addr   = best_n + AW'(1);
            state_nxt = ST_NEXT;
          end else begin
            finish = 1'b1;
          end
        end
      end

      ST_PREV: begin
        if (gap < best_gap_r) begin
          best_n = mid_r;
          gap_n  = gap;
        end
        if ((CW'(best_n) + ONE_C) < count_r) begin
          mid_nxt   = best_n + AW'(1);
          rd_addr   = best_n + AW'(1);
          state_nxt = ST_NEXT;
        end else begin
          finish = 1'b1;
        end
      end

      ST_NEXT: begin
        if (gap < best_gap_r) begin
          best_n = mid_r;
          gap_n  = gap;
        end
        finish = 1'b1;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    best_nxt     = best_n;
    best_gap_nxt = gap_n;

    // A zero gap at the chosen entry means the stored timestamp equals the key.
    if (finish) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = STATUS_OK;
      out_index_nxt  = best_n;
      out_exact_nxt  = (gap_n == '0);
      state_nxt      = ST_IDLE;
    end
  end

  assign index_ext = IW'(out_index_r);

  assign busy            = (state_r != ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_index = index_ext[FOUND_W-1:0];
  assign out_exact_match = out_exact_r;

  // A result is only ever shown with the sequencer back at rest.
  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == ST_IDLE))
    else $error("result shown while the search is still running");

  // Every result follows a transfer or the end of a search.
  a_result_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(accept) || $past(state_r != ST_IDLE)))
    else $error("result without a request behind it");

  // The entry count never runs past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above table depth");

  // A probe always looks at a non-empty range.
  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PROBE) |-> ((lo_r < hi_r) && (CW'(mid_r) >= lo_r) && (CW'(mid_r) < hi_r)))
    else $error("probe outside the search range");

  // A query on a non-empty table starts the search rather than answering at once.
  a_query_searches: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_req_type == REQ_QUERY) && (count_r != '0)) |=> (busy && !out_valid_r))
    else $error("query answered without a search");

endmodule

// File: bench/tb_nearest_timestamp_search.sv
`timescale 1ns / 100ps
// Self-checking testbench for the nearest-timestamp search table with a built-in predictor.
module tb_nearest_timestamp_search;
  import nts_pkg::*;

  // The default depth is kept so that the full-table case and the widest index both come up.
  localparam int unsigned TABLE_DEPTH = 1024;
  // A short quiet tail follows the last owed result, so a stray late result still shows up.
  localparam int unsigned DRAIN_TAIL = 20;
  // The longest correct quiet stretch is the drain tail plus the longest sender gap; this
  // is many times that.
  localparam int unsigned WATCHDOG_LIMIT = 400;
  localparam int unsigned SESSION_ITEMS = 450;

  // One expected result, laid out like the result ports.
  typedef struct packed {
    status_t              status;
    logic [FOUND_W-1:0]   index;
    logic                 exact;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  req_t                 in_req_type = REQ_APPEND;
  time_t                in_time_value = '0;
  logic                 out_valid;
  status_t              out_status;
  logic [FOUND_W-1:0]   out_found_index;
  logic                 out_exact_match;

  // Predictor state: a private copy of the table and its fill level.
  time_t                stamps [TABLE_DEPTH];
  int unsigned          stored_count = 0;
  time_t                last_stamp = '0;

  // Results that the block still owes, oldest first.
  reply_t               expected_replies [$];
  reply_t               reply_want;

  // When set, the sender issues requests back to back with no gaps.
  bit                   burst_mode = 1'b0;
  int unsigned          mismatches = 0;
  int unsigned          idle_cycles = 0;
  int unsigned          sent_count = 0;
  int unsigned          n_appends = 0;
  int unsigned          n_refused = 0;
  int unsigned          n_queries = 0;
  int unsigned          n_exact = 0;
  int unsigned          n_empty = 0;
  int unsigned          n_clears = 0;
  int unsigned          n_unused = 0;

  nearest_timestamp_search #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_time_value  (in_time_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_found_index(out_found_index),
    .out_exact_match(out_exact_match)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  function automatic time_t time_distance(input time_t a, input time_t b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // Binary search over the stored entries. An exact probe ends the search. Otherwise the
  // closest probe wins, the earlier one on a tie, and then the entry before it and the
  // entry after the possibly moved index each get one chance to beat it strictly.
  function automatic int nearest_slot(input time_t key);
    int    lo;
    int    hi;
    int    mid;
    int    best;
    time_t gap;
    time_t best_gap;
    bit    have;
    lo = 0;
    hi = int'(stored_count) - 1;
    best = 0;
    best_gap = '0;
    have = 1'b0;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      gap = time_distance(stamps[mid], key);
      if (!have || gap < best_gap) begin
        have = 1'b1;
        best_gap = gap;
        best = mid;
      end
      if (stamps[mid] == key) return mid;
      if (stamps[mid] < key) lo = mid + 1;
      else hi = mid - 1;
    end
    if (best > 0) begin
      gap = time_distance(stamps[best-1], key);
      if (gap < best_gap) begin
        best_gap = gap;
        best = best - 1;
      end
    end
    if (best + 1 < int'(stored_count)) begin
      gap = time_distance(stamps[best+1], key);
      if (gap < best_gap) best = best + 1;
    end
    return best;
  endfunction

  // Applies one accepted request to the private copy and returns the result it must cause.
  function automatic reply_t predict_reply(input req_t req, input time_t tv);
    reply_t r;
    int     slot;
    r = '0;
    case (req)
      REQ_APPEND: begin
        n_appends++;
        if (stored_count >= TABLE_DEPTH) begin
          r.status = STATUS_FULL;
          n_refused++;
        end else begin
          stamps[stored_count] = tv;
          stored_count++;
        end
      end
      REQ_QUERY: begin
        n_queries++;
        if (stored_count == 0) begin
          r.status = STATUS_EMPTY;
          n_empty++;
        end else begin
          slot = nearest_slot(tv);
          r.index = FOUND_W'(slot);
          r.exact = (stamps[slot] == tv);
          if (r.exact) n_exact++;
        end
      end
      REQ_CLEAR: begin
        stored_count = 0;
        n_clears++;
      end
      default: n_unused++;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------------------

  // Next timestamp of an ascending series. Tiny steps give duplicates and ties, large ones
  // spread the table; the series saturates at the top of the range.
  function automatic time_t next_stamp();
    longint unsigned nxt;
    if ($urandom_range(0, 3) == 0) nxt = longint'(last_stamp) + $urandom_range(0, 2);
    else nxt = longint'(last_stamp) + $urandom_range(0, 4000000);
    if (nxt > 64'hFFFF_FFFF) nxt = 64'hFFFF_FFFF;
    last_stamp = time_t'(nxt);
    return last_stamp;
  endfunction

  // A key that lands on, next to or halfway between stored entries, or anywhere at all.
  function automatic time_t pick_key();
    int unsigned     slot;
    longint unsigned mid;
    if (stored_count == 0) return $urandom;
    slot = $urandom_range(0, stored_count - 1);
    case ($urandom_range(0, 5))
      0, 1: return stamps[slot];
      2: return stamps[slot] + $urandom_range(0, 6) - 3;
      3: begin
        if (slot + 1 >= stored_count) return stamps[slot] + 1;
        mid = (longint'(stamps[slot]) + longint'(stamps[slot+1])) >> 1;
        return time_t'(mid);
      end
      4: return $urandom;
      default: return $urandom_range(0, 1) ? '0 : '1;
    endcase
  endfunction

  // Sends one request and returns at the edge where its transfer happens. Start is left
  // high afterwards so that a back-to-back request never lowers and raises it in one step.
  task automatic send_request(input req_t req, input time_t tv);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req_type <= req;
    in_time_value <= tv;
    do @(posedge clk); while (busy);
    expected_replies.push_back(predict_reply(req, tv));
    sent_count++;
  endtask

  // One random request. Most are appends or queries by the given weight; a few are noise:
  // the unused code, or an append that breaks the ascending order.
  task automatic send_random_item(input int unsigned append_weight);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3) send_request(REQ_UNUSED, $urandom);
    else if (pick < 7) send_request(REQ_APPEND, $urandom);
    else if (pick < append_weight) send_request(REQ_APPEND, next_stamp());
    else send_request(REQ_QUERY, pick_key());
  endtask

  // Lowers start and lets every owed result arrive, then waits out the drain tail.
  task automatic wait_all_replies();
    start <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------------

  // Queries and clears on an empty table, and the unused request code.
  task automatic test_empty_and_unused();
    send_request(REQ_QUERY, '0);
    send_request(REQ_UNUSED, '1);
    send_request(REQ_CLEAR, '1);
    send_request(REQ_QUERY, '1);
    wait_all_replies();
  endtask

  // A small hand-built table: duplicates, ties, both ends of the time range, an append out
  // of order, and a clear followed by an empty query.
  task automatic test_directed_search();
    send_request(REQ_APPEND, '0);
    send_request(REQ_APPEND, 32'd10);
    send_request(REQ_APPEND, 32'd20);
    send_request(REQ_APPEND, 32'd20);
    send_request(REQ_APPEND, 32'd30);
    send_request(REQ_APPEND, '1);
    send_request(REQ_QUERY, 32'd20);
    send_request(REQ_QUERY, 32'd15);
    send_request(REQ_QUERY, 32'd14);
    send_request(REQ_QUERY, 32'd16);
    send_request(REQ_QUERY, 32'd25);
    send_request(REQ_QUERY, '0);
    send_request(REQ_QUERY, '1);
    send_request(REQ_QUERY, 32'h7FFF_FFFF);
    send_request(REQ_UNUSED, 32'd20);
    send_request(REQ_APPEND, 32'd5);
    send_request(REQ_QUERY, 32'd5);
    send_request(REQ_CLEAR, '0);
    send_request(REQ_QUERY, 32'd7);
    wait_all_replies();
  endtask

  // Fills the table to capacity with ascending random stamps and queries mixed in, then
  // checks that further appends are refused while queries still see every entry.
  task automatic test_fill_to_capacity();
    send_request(REQ_CLEAR, '0);
    last_stamp = $urandom_range(0, 1000);
    while (stored_count < TABLE_DEPTH) begin
      if (sent_count % 64 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      send_random_item(80);
    end
    burst_mode = 1'b0;
    repeat (6) send_request(REQ_APPEND, next_stamp());
    send_request(REQ_APPEND, $urandom);
    repeat (40) send_request(REQ_QUERY, pick_key());
    send_request(REQ_CLEAR, '0);
    send_request(REQ_QUERY, $urandom);
    wait_all_replies();
  endtask

  // Short sessions: usually a clear, a burst of ascending appends from a random base, then a
  // burst of queries. Some sessions keep the old entries or query before appending.
  task automatic test_random_sessions();
    int unsigned target;
    int unsigned n_items;
    target = sent_count + SESSION_ITEMS;
    while (sent_count < target) begin
      burst_mode = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) send_request(REQ_CLEAR, $urandom);
      if ($urandom_range(0, 5) == 0) send_request(REQ_QUERY, $urandom);
      last_stamp = $urandom;
      n_items = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
      repeat (n_items) send_random_item(100);
      n_items = $urandom_range(1, 15);
      repeat (n_items) send_random_item(7);
    end
    burst_mode = 1'b0;
    wait_all_replies();
  endtask

  // ---------------------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------------------

  task automatic note_mismatch(input string field, input logic [31:0] want_v,
                               input logic [31:0] got_v);
    mismatches++;
    if (mismatches <= 10)
      $display("Mismatch in %s at %0t: expected %0d, got %0d", field, $time, want_v, got_v);
  endtask

  // Every strobed result is taken at the edge that ends its cycle and is compared with the
  // oldest owed result, one field at a time.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (expected_replies.size() == 0) begin
        note_mismatch("result transfer with nothing owed, status", '0, 32'(out_status));
      end else begin
        reply_want = expected_replies.pop_front();
        if (out_status !== reply_want.status)
          note_mismatch("status", 32'(reply_want.status), 32'(out_status));
        if (out_found_index !== reply_want.index)
          note_mismatch("found_index", 32'(reply_want.index), 32'(out_found_index));
        if (out_exact_match !== reply_want.exact)
          note_mismatch("exact_match", 32'(reply_want.exact), 32'(out_exact_match));
      end
    end else if (rst_n && out_valid !== 1'b0) begin
      note_mismatch("out_valid", '0, 32'(out_valid));
    end
  end

  // The watchdog counts cycles with neither a request nor a result transfer.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog expired with %0d results still owed", expected_replies.size());
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------------

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_and_unused();
    test_directed_search();
    test_fill_to_capacity();
    test_random_sessions();
    $display("Sent %0d requests: %0d appends (%0d refused on a full table), %0d clears, %0d unused",
             sent_count, n_appends, n_refused, n_clears, n_unused);
    $display("Ran %0d queries: %0d exact hits, %0d on an empty table; %0d mismatches",
             n_queries, n_exact, n_empty, mismatches);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: nearest_timestamp_search.f
design/nts_pkg.sv
design/nearest_timestamp_search.sv
bench/tb_nearest_timestamp_search.sv
